FILE: sv/mrss_pkg.sv
// ----------------------------------------------------------------------------
// mrss_pkg: shared types and constants for masked region SNR statistics
// Field widths, register indexes, status codes and the front/back word type.
// ----------------------------------------------------------------------------
`default_nettype none
package mrss_pkg;
  localparam int unsigned ImageDimDefault = 1024;
  localparam int unsigned CoordW = 10;
  localparam int unsigned CntW = 21;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [2:0] RegFlagMask = 3'd0;
  localparam logic [2:0] RegColFirst = 3'd1;
  localparam logic [2:0] RegColFinal = 3'd2;
  localparam logic [2:0] RegRowFirst = 3'd3;
  localparam logic [2:0] RegRowFinal = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StEmpty    = 3'd1;
  localparam logic [2:0] StNoErr    = 3'd2;
  localparam logic [2:0] StBad      = 3'd3;
  localparam logic [2:0] StFlagged  = 3'd4;

  // classified pixel passed from the front to the back
  typedef struct packed {
    logic               use_px;   // inside window, flags clear
    logic               bad_err;  // err <= 0
    logic signed [31:0] sci;
    logic signed [31:0] err;
    logic               last;
  } px_t;
endpackage
`default_nettype wire

FILE: sv/mrss_front.sv
// ----------------------------------------------------------------------------
// mrss_front: window and flag classification of incoming pixels
// Decides per pixel whether it is used and whether its error is bad.
// ----------------------------------------------------------------------------
`default_nettype none
module mrss_front import mrss_pkg::*; (
  input  wire logic [CoordW-1:0] column_i,
  input  wire logic [CoordW-1:0] row_i,
  input  wire logic [31:0]       sci_i,
  input  wire logic [31:0]       err_i,
  input  wire logic [15:0]       dq_i,
  input  wire logic              last_i,
  input  wire logic [15:0]       flag_mask_i,
  input  wire logic [CoordW-1:0] col_first_i,
  input  wire logic [CoordW-1:0] cf_i,
  input  wire logic [CoordW-1:0] row_first_i,
  input  wire logic [CoordW-1:0] rf_i,
  output px_t                    px_o
);
  logic in_win;
  assign in_win = (column_i >= col_first_i) && (column_i <= cf_i) &&
                  (row_i >= row_first_i) && (row_i <= rf_i);
  always_comb begin
    px_o.use_px  = in_win && ((dq_i & flag_mask_i) == 16'd0);
    px_o.bad_err = $signed(err_i) <= 32'sd0;
    px_o.sci     = $signed(sci_i);
    px_o.err     = $signed(err_i);
    px_o.last    = last_i;
  end
endmodule
`default_nettype wire

FILE: sv/mrss_fifo.sv
// ----------------------------------------------------------------------------
// mrss_fifo: two-entry queue between the front and the back
// Registered storage with a valid/ready handshake on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module mrss_fifo import mrss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire px_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output px_t       out_data_o
);
  px_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rd_q];
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: sv/mrss_div.sv
// ----------------------------------------------------------------------------
// mrss_div: radix-2 restoring divider, signed, truncating toward zero
// One quotient bit per cycle over a 64-bit dividend and a 33-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module mrss_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] num_i,
  input  wire logic signed [32:0] den_i,   // nonzero
  output logic                    done_o,
  output logic signed [63:0]      quo_o
);
  logic [63:0] q_q, q_d;
  logic [32:0] r_q, r_d;
  logic [32:0] d_q;
  logic        neg_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [33:0] trial;
  logic [63:0] num_abs;
  logic [32:0] den_abs;

  assign num_abs = num_i[63] ? 64'(-num_i) : num_i;
  assign den_abs = den_i[32] ? 33'(-den_i) : den_i;
  assign trial   = {r_q, q_q[63]} - {1'b0, d_q};
  always_comb begin
    if (!trial[33]) begin
      r_d = trial[32:0];
      q_d = {q_q[62:0], 1'b1};
    end else begin
      r_d = {r_q[31:0], q_q[63]};
      q_d = {q_q[62:0], 1'b0};
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_abs; r_q <= '0; d_q <= den_abs;
      neg_q <= num_i[63] ^ den_i[32];
    end else if (busy_q) begin
      q_q <= q_d; r_q <= r_d;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; cnt_q <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0; done_q <= 1'b1;
        end
      end
    end
  end
  assign done_o = done_q;
  assign quo_o  = neg_q ? 64'(-q_q) : q_q;
endmodule
`default_nettype wire

FILE: sv/mrss_back.sv
// ----------------------------------------------------------------------------
// mrss_back: accumulation and frame report sequencer
// Ratio per accepted pixel, sums and extrema, then means on frame end.
// ----------------------------------------------------------------------------
`default_nettype none
module mrss_back import mrss_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              px_valid_i,
  output logic                   px_ready_o,
  input  wire px_t               px_i,
  input  wire logic [CoordW-1:0] col_first_i,
  input  wire logic [CoordW-1:0] cf_i,
  input  wire logic [CoordW-1:0] row_first_i,
  input  wire logic [CoordW-1:0] rf_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic [311:0]           res_o
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_SNR  = 8'b00000010, S_ACC  = 8'b00000100,
    S_AREA = 8'b00001000, S_MSCI = 8'b00010000, S_MERR = 8'b00100000,
    S_MSNR = 8'b01000000, S_OUT  = 8'b10000000
  } state_e;
  state_e state_q;

  logic [CntW-1:0] acc_q, bad_q;
  logic signed [63:0] sci_sum_q, err_sum_q, snr_sum_q;
  logic signed [31:0] sci_lo_q, sci_hi_q, err_lo_q, err_hi_q, snr_lo_q, snr_hi_q;
  logic signed [31:0] sci_q, err_q, snr_c;
  logic               last_q;
  logic signed [31:0] m_sci_q, m_snr_q;
  logic [30:0]        m_err_q;
  logic [2:0]         st_c;
  logic [20:0]        area_q;
  logic               area_ok_q;
  logic               res_valid_q;
  logic [311:0]       res_q;

  logic               div_start, div_done;
  logic signed [63:0] div_num, div_q;
  logic signed [32:0] div_den;
  logic               take;
  logic               first;

  assign px_ready_o = (state_q == S_IDLE);
  assign take = px_valid_i && px_ready_o;
  assign first = acc_q == '0;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 33'sd1;
    case (state_q)
      S_IDLE: begin
        div_num = {{16{px_i.sci[31]}}, px_i.sci, 16'd0};
        div_den = {px_i.err[31], px_i.err};
        div_start = take && px_i.use_px && !px_i.bad_err && acc_q != CntMax;
      end
      S_AREA: begin
        div_num = sci_sum_q; div_den = {12'd0, acc_q};
        div_start = acc_q != '0;
      end
      S_MSCI: begin
        div_num = err_sum_q; div_den = {12'd0, acc_q};
        div_start = div_done;
      end
      S_MERR: begin
        div_num = snr_sum_q; div_den = {12'd0, acc_q};
        div_start = div_done;
      end
      default: ;
    endcase
  end

  mrss_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_q)
  );

  always_comb begin
    if (div_q > 64'sh7FFFFFFF) snr_c = 32'sh7FFFFFFF;
    else if (div_q < -64'sh80000000) snr_c = 32'sh80000000;
    else snr_c = div_q[31:0];
  end

  logic [10:0] cw, rw;
  assign cw = {1'b0, cf_i} - {1'b0, col_first_i} + 11'd1;
  assign rw = {1'b0, rf_i} - {1'b0, row_first_i} + 11'd1;

  always_ff @(posedge clk_i) begin
    if (take) begin
      sci_q <= px_i.sci; err_q <= px_i.err; last_q <= px_i.last;
    end
    if (state_q == S_SNR && div_done) begin
      sci_lo_q <= (first || sci_q < sci_lo_q) ? sci_q : sci_lo_q;
      sci_hi_q <= (first || sci_q > sci_hi_q) ? sci_q : sci_hi_q;
      err_lo_q <= (first || err_q < err_lo_q) ? err_q : err_lo_q;
      err_hi_q <= (first || err_q > err_hi_q) ? err_q : err_hi_q;
      snr_lo_q <= (first || snr_c < snr_lo_q) ? snr_c : snr_lo_q;
      snr_hi_q <= (first || snr_c > snr_hi_q) ? snr_c : snr_hi_q;
    end
    if (state_q == S_ACC) begin
      area_ok_q <= (col_first_i <= cf_i) && (row_first_i <= rf_i);
      area_q <= {10'd0, cw} * {10'd0, rw};
    end
    if (state_q == S_MSCI && div_done) m_sci_q <= div_q[31:0];
    if (state_q == S_MERR && div_done) m_err_q <= div_q[30:0];
    if (state_q == S_MSNR && div_done) m_snr_q <= div_q[31:0];
    if (state_q == S_OUT && !res_valid_q) begin
      if (acc_q != '0) begin
        res_q <= {3'd0, StOk, snr_hi_q, snr_lo_q, m_snr_q, err_hi_q[30:0],
                  err_lo_q[30:0], m_err_q, sci_hi_q, sci_lo_q, m_sci_q, acc_q};
      end else begin
        res_q <= {3'd0, st_c, 306'd0};
      end
    end
  end

  always_comb begin
    if (!area_ok_q) st_c = StEmpty;
    else if (bad_q != '0) st_c = (bad_q == area_q) ? StNoErr : StBad;
    else st_c = StFlagged;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q <= '0; bad_q <= '0; res_valid_q <= 1'b0;
      sci_sum_q <= '0; err_sum_q <= '0; snr_sum_q <= '0;
    end else begin
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (take) begin
          if (px_i.use_px && px_i.bad_err && bad_q != CntMax) bad_q <= bad_q + 1'b1;
          if (div_start) state_q <= S_SNR;
          else if (px_i.last) state_q <= S_ACC;
        end
        S_SNR: if (div_done) begin
          acc_q <= acc_q + 1'b1;
          sci_sum_q <= sci_sum_q + 64'(sci_q);
          err_sum_q <= err_sum_q + 64'(err_q);
          snr_sum_q <= snr_sum_q + 64'(snr_c);
          state_q <= last_q ? S_ACC : S_IDLE;
        end
        S_ACC:  state_q <= S_AREA;
        S_AREA: state_q <= (acc_q != '0) ? S_MSCI : S_OUT;
        S_MSCI: if (div_done) state_q <= S_MERR;
        S_MERR: if (div_done) state_q <= S_MSNR;
        S_MSNR: if (div_done) state_q <= S_OUT;
        S_OUT: if (!res_valid_q) begin
          res_valid_q <= 1'b1;
          acc_q <= '0; bad_q <= '0;
          sci_sum_q <= '0; err_sum_q <= '0; snr_sum_q <= '0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

FILE: sv/masked_region_snr_statistics.sv
// ----------------------------------------------------------------------------
// masked_region_snr_statistics: windowed, flag-masked SNR statistics
// Per frame count, means and extrema of science, error and SNR.
// ----------------------------------------------------------------------------
// channel   dir  fields (tdata from bit 0)
// s_axis    in   column, row, sci_value, err_value, dq_flags; tlast frame_end
// m_axis    out  good_count, sci_mean/min/max, err_mean/min/max,
//                snr_mean/min/max, status
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// A used pixel with positive error waits for the shared serial divider
// (one quotient bit per cycle); other pixels pass without a division.
// Frame end with accepted pixels adds three divisions for the means;
// without accepted pixels it goes straight to the result word.
// Reset clears all statistics; registers return to the full window.
// A two-entry queue lets input keep arriving while the back side works;
// the back side holds a finished frame until the previous word is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module masked_region_snr_statistics import mrss_pkg::*; #(
  parameter int unsigned IMAGE_DIM = ImageDimDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [103:0] s_axis_tdata,  // column, row, sci, err, dq_flags
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [311:0]      m_axis_tdata,  // count, sci x3, err x3, snr x3, status
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);
  localparam int unsigned LimInt =
    (IMAGE_DIM > (1 << CoordW)) ? (1 << CoordW) - 1 : IMAGE_DIM - 1;
  localparam logic [CoordW-1:0] Lim = CoordW'(LimInt);
  logic [15:0]       mask_q;
  logic [CoordW-1:0] cfirst_q, cfinal_q, rfirst_q, rfinal_q, cf, rf;
  px_t  px_f, px_b;
  logic fb_valid, fb_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0; cfirst_q <= '0; cfinal_q <= '1; rfirst_q <= '0; rfinal_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFlagMask: mask_q <= cfg_data_i;
        RegColFirst: cfirst_q <= cfg_data_i[CoordW-1:0];
        RegColFinal: cfinal_q <= cfg_data_i[CoordW-1:0];
        RegRowFirst: rfirst_q <= cfg_data_i[CoordW-1:0];
        RegRowFinal: rfinal_q <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end
  assign cf = (cfinal_q > Lim) ? Lim : cfinal_q;
  assign rf = (rfinal_q > Lim) ? Lim : rfinal_q;

  mrss_front u_front (
    .column_i(s_axis_tdata[9:0]), .row_i(s_axis_tdata[19:10]),
    .sci_i(s_axis_tdata[51:20]), .err_i(s_axis_tdata[83:52]),
    .dq_i(s_axis_tdata[99:84]), .last_i(s_axis_tlast),
    .flag_mask_i(mask_q), .col_first_i(cfirst_q), .cf_i(cf),
    .row_first_i(rfirst_q), .rf_i(rf), .px_o(px_f)
  );

  mrss_fifo u_fifo (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(px_f), .out_valid_o(fb_valid), .out_ready_i(fb_ready),
    .out_data_o(px_b)
  );

  mrss_back u_back (
    .clk_i, .rst_ni, .px_valid_i(fb_valid), .px_ready_o(fb_ready), .px_i(px_b),
    .col_first_i(cfirst_q), .cf_i(cf), .row_first_i(rfirst_q), .rf_i(rf),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(m_axis_tdata)
  );

`ifndef SYNTH
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[308:306] <= StFlagged) else $error("bad status");
  a_zero_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[20:0] == 21'd0) |-> m_axis_tdata[305:21] == '0)
    else $error("nonzero stats with empty count");
  a_ok_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[308:306] == StOk) |-> m_axis_tdata[20:0] != 21'd0)
    else $error("ok status without pixels");
`endif
endmodule
`default_nettype wire

FILE: test/mrss_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrss_checker: scoreboard for masked region SNR statistics
// Watches config writes and both stream channels, keeps its own copy of the
// window, mask and running statistics, and compares each frame result word
// field by field against the oldest predicted frame result.
// ----------------------------------------------------------------------------
module mrss_checker import mrss_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [311:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] snr_max;
    logic signed [31:0] snr_min;
    logic signed [31:0] snr_mean;
    logic [30:0]        err_max;
    logic [30:0]        err_min;
    logic [30:0]        err_mean;
    logic signed [31:0] sci_max;
    logic signed [31:0] sci_min;
    logic signed [31:0] sci_mean;
    logic [20:0]        good_count;
  } frame_stats_t;

  localparam logic [9:0] IMAGE_DIM_M1 = 10'(ImageDimDefault - 1);

  logic [15:0] mask_q;
  logic [9:0]  cf_q, cl_q, rf_q, rl_q;
  logic [20:0] n_good, n_bad;
  longint      sum_sci, sum_err, sum_snr;
  int          lo_sci, hi_sci, lo_err, hi_err, lo_snr, hi_snr;
  frame_stats_t frame_q[$];

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  task automatic clear_stats();
    n_good = 0; n_bad = 0; sum_sci = 0; sum_err = 0; sum_snr = 0;
    lo_sci = 0; hi_sci = 0; lo_err = 0; hi_err = 0; lo_snr = 0; hi_snr = 0;
  endtask

  task automatic absorb_pixel(input logic [103:0] d, input logic last);
    logic [9:0] col, row, cfc, rfc;
    int sci, err, snr;
    longint q, area;
    frame_stats_t r;
    col = d[9:0]; row = d[19:10]; sci = d[51:20]; err = d[83:52];
    cfc = cl_q; rfc = rl_q;
    if (cfc > IMAGE_DIM_M1) cfc = IMAGE_DIM_M1;
    if (rfc > IMAGE_DIM_M1) rfc = IMAGE_DIM_M1;
    if (col >= cf_q && col <= cfc && row >= rf_q && row <= rfc
        && (d[99:84] & mask_q) == 0) begin
      if (err <= 0) begin
        if (n_bad != CntMax) n_bad++;
      end else if (n_good != CntMax) begin
        q = (longint'(sci) * 65536) / longint'(err);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        snr = int'(q);
        if (n_good == 0) begin
          lo_sci = sci; hi_sci = sci; lo_err = err; hi_err = err;
          lo_snr = snr; hi_snr = snr;
        end else begin
          if (sci < lo_sci) lo_sci = sci;
          if (sci > hi_sci) hi_sci = sci;
          if (err < lo_err) lo_err = err;
          if (err > hi_err) hi_err = err;
          if (snr < lo_snr) lo_snr = snr;
          if (snr > hi_snr) hi_snr = snr;
        end
        sum_sci += sci; sum_err += err; sum_snr += snr;
        n_good++;
      end
    end
    if (!last) return;
    r = '0;
    if (n_good != 0) begin
      r.good_count = n_good;
      r.sci_mean = 32'(sum_sci / longint'(n_good));
      r.sci_min = lo_sci; r.sci_max = hi_sci;
      r.err_mean = 31'(sum_err / longint'(n_good));
      r.err_min = 31'(lo_err); r.err_max = 31'(hi_err);
      r.snr_mean = 32'(sum_snr / longint'(n_good));
      r.snr_min = lo_snr; r.snr_max = hi_snr;
      r.status = StOk;
    end else begin
      area = 0;
      if (cf_q <= cfc && rf_q <= rfc)
        area = longint'(cfc - cf_q + 1) * longint'(rfc - rf_q + 1);
      if (area == 0) r.status = StEmpty;
      else if (n_bad != 0) r.status = (longint'(n_bad) == area) ? StNoErr : StBad;
      else r.status = StFlagged;
    end
    frame_q.push_back(r);
    clear_stats();
  endtask

  task automatic compare_frame(input frame_stats_t got);
    frame_stats_t w;
    if (frame_q.size() == 0) begin
      $display("unexpected result word at %0t", $realtime);
      fail_count_o++;
      return;
    end
    w = frame_q.pop_front();
    if (got.good_count != w.good_count) report("good_count", got.good_count, w.good_count);
    if (got.sci_mean != w.sci_mean) report("sci_mean", got.sci_mean, w.sci_mean);
    if (got.sci_min != w.sci_min) report("sci_min", got.sci_min, w.sci_min);
    if (got.sci_max != w.sci_max) report("sci_max", got.sci_max, w.sci_max);
    if (got.err_mean != w.err_mean) report("err_mean", got.err_mean, w.err_mean);
    if (got.err_min != w.err_min) report("err_min", got.err_min, w.err_min);
    if (got.err_max != w.err_max) report("err_max", got.err_max, w.err_max);
    if (got.snr_mean != w.snr_mean) report("snr_mean", got.snr_mean, w.snr_mean);
    if (got.snr_min != w.snr_min) report("snr_min", got.snr_min, w.snr_min);
    if (got.snr_max != w.snr_max) report("snr_max", got.snr_max, w.snr_max);
    if (got.status != w.status) report("status", got.status, w.status);
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    mask_q = 0; cf_q = 0; cl_q = 10'd1023; rf_q = 0; rl_q = 10'd1023;
    clear_stats();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegFlagMask: mask_q = cfg_data_i;
          RegColFirst: cf_q = cfg_data_i[9:0];
          RegColFinal: cl_q = cfg_data_i[9:0];
          RegRowFirst: rf_q = cfg_data_i[9:0];
          RegRowFinal: rl_q = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) absorb_pixel(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) compare_frame(m_axis_tdata[308:0]);
      pending_o = frame_q.size();
    end
  end
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus for masked region SNR statistics
// Directed corner frames, then random frames under several window and mask
// settings with source gaps and sink stalls; checking lives in mrss_checker.
// ----------------------------------------------------------------------------
module tb_top import mrss_pkg::*;;
  logic         clk_i = 0, rst_ni = 0;
  logic         s_axis_tvalid = 0, s_axis_tready, s_axis_tlast = 0;
  logic [103:0] s_axis_tdata = '0;  // column, row, sci, err, dq_flags, pad
  logic         m_axis_tvalid, m_axis_tready = 0;
  logic [311:0] m_axis_tdata;       // count, sci x3, err x3, snr x3, status
  logic         cfg_we_i = 0;
  logic [2:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;
  int           fail_count, pending, send_idle, sink_stall, hold_cycles;
  longint       cycle_count;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  masked_region_snr_statistics u_top (.*);

  mrss_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // sink: random stalls plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("masked_region_snr_statistics test failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row,
                            input logic [31:0] sci, input logic [31:0] err,
                            input logic [15:0] dq, input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, dq, err, sci, row, col};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_window(input logic [15:0] mask, input logic [9:0] c0,
                            input logic [9:0] c1, input logic [9:0] r0, input logic [9:0] r1);
    write_reg(RegFlagMask, mask); write_reg(RegColFirst, {6'd0, c0});
    write_reg(RegColFinal, {6'd0, c1}); write_reg(RegRowFirst, {6'd0, r0});
    write_reg(RegRowFinal, {6'd0, r1});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(8) - 4;
      3: return $signed($urandom_range(400000)) - 200000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_frame(input int len, input logic [9:0] c0, input logic [9:0] c1,
                              input logic [9:0] r0, input logic [9:0] r1);
    logic [9:0] col, row;
    logic [31:0] err;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(3) == 0) begin
        col = 10'($urandom); row = 10'($urandom);
      end else begin
        col = (c0 <= c1) ? 10'($urandom_range(c1, c0)) : 10'($urandom);
        row = (r0 <= r1) ? 10'($urandom_range(r1, r0)) : 10'($urandom);
      end
      err = ($urandom_range(4) == 0) ? 32'($signed(-$urandom_range(3))) : rand_value();
      if ($urandom_range(3) == 0) err = $urandom_range(200000, 1);
      send_pixel(col, row, rand_value(), err,
                 ($urandom_range(2) == 0) ? 16'($urandom) : 16'h0, i == len - 1);
    end
  endtask

  task automatic random_phase(input int frames);
    logic [9:0] c0, c1, r0, r1;
    c0 = 10'($urandom_range(40)); c1 = c0 + 10'($urandom_range(40));
    r0 = 10'($urandom_range(1023));
    r1 = ($urandom_range(3) == 0) ? 10'd1023 : r0 + 10'd20;
    if ($urandom_range(5) == 0) begin
      c0 = 10'd1023; c1 = 10'd1023;
    end
    drain();
    set_window(($urandom_range(1) == 0) ? 16'h0 : 16'($urandom), c0, c1, r0, r1);
    repeat (frames) random_frame($urandom_range(12, 1), c0, c1, r0, r1);
  endtask

  initial begin
    cycle_count = 0; send_idle = 0; sink_stall = 0; hold_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: reset window, extremes, saturation, single pixel
    send_pixel(10'd0, 10'd0, 32'h7fff_ffff, 32'd1, 16'h0, 1'b0);
    send_pixel(10'd1023, 10'd1023, 32'h8000_0000, 32'd1, 16'hffff, 1'b0);
    send_pixel(10'd5, 10'd7, 32'h8000_0000, 32'h7fff_ffff, 16'h0, 1'b1);
    send_pixel(10'd1, 10'd1, 32'd0, 32'd0, 16'h0, 1'b1);            // all bad
    drain();
    set_window(16'h0001, 10'd2, 10'd3, 10'd4, 10'd4);              // area 2
    send_pixel(10'd2, 10'd4, 32'd100, 32'h8000_0000, 16'h0, 1'b0);
    send_pixel(10'd3, 10'd4, 32'd100, 32'd0, 16'h0, 1'b1);          // bad == area
    send_pixel(10'd2, 10'd4, 32'd9, 32'd0, 16'h0, 1'b1);            // bad < area
    send_pixel(10'd2, 10'd4, 32'd9, 32'd5, 16'h0001, 1'b1);         // all flagged
    send_pixel(10'd9, 10'd9, 32'd9, 32'd5, 16'h0, 1'b1);            // outside
    send_pixel(10'd3, 10'd4, 32'hffff_fff9, 32'd3, 16'hfffe, 1'b1);
    drain();
    set_window(16'h0, 10'd9, 10'd8, 10'd0, 10'd1023);              // empty
    send_pixel(10'd9, 10'd9, 32'd1, 32'd1, 16'h0, 1'b1);
    drain();
    set_window(16'hffff, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_pixel(10'd1023, 10'd1023, 32'd1, 32'd1, 16'h0, 1'b1);
    send_pixel(10'd1023, 10'd1023, 32'h1234_5678, 32'h0000_0100, 16'h0, 1'b1);
    // random phases under the idling schedule
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 79 : 32) : 0;
      sink_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 79 : 32) : 0;
      for (int k = 0; k < 10; k++) random_phase(6);
    end
    // long sink hold-off while the source keeps pushing frames
    send_idle = 0; sink_stall = 0;
    drain();
    set_window(16'h0, 10'd0, 10'd1023, 10'd0, 10'd1023);
    hold_cycles = 3000;
    repeat (8) random_frame(2, 10'd0, 10'd1023, 10'd0, 10'd1023);
    drain();
    if (fail_count == 0) begin
      $display("masked_region_snr_statistics test passed");
    end else begin
      $display("masked_region_snr_statistics test failed");
    end
    $finish;
  end
endmodule
